FILE: rtl/pu_pkg.sv
package pu_pkg;

  // sizes
  localparam int MAX_ELEMENTS = 16;
  localparam int RANK_W       = 45;
  localparam int SIZE_W       = 5;
  localparam int POS_W        = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  localparam int N_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int DIG_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(RANK_W + 1);

  // compares done per cycle in the adjust pass
  localparam int ADJ_LANES = (MAX_ELEMENTS - 1 < 4) ? MAX_ELEMENTS - 1 : 4;

  // elaboration helpers
  function automatic logic [63:0] fact_of(int k);
    logic [63:0] f;
    f = 64'd1;
    for (int i = 2; i <= k; i++) begin
      f = f * 64'(i);
    end
    return f;
  endfunction

  function automatic int bit_len(logic [63:0] v);
    int r;
    r = 0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        r = i + 1;
      end
    end
    return r;
  endfunction

  localparam int FACT_MAX_W = bit_len(fact_of(MAX_ELEMENTS));
  localparam int DIV_W      = (FACT_MAX_W > RANK_W) ? FACT_MAX_W : RANK_W;

  typedef logic [DIV_W-1:0] pu_div_t;
  typedef pu_div_t          pu_div_tbl_t [MAX_ELEMENTS+1];
  typedef logic [CNT_W-1:0] pu_cnt_tbl_t [MAX_ELEMENTS+1];

  // modulo reduction: n! aligned to the top of the rank
  function automatic pu_div_tbl_t build_mod_div();
    pu_div_tbl_t t;
    logic [63:0] f;
    int          len;
    for (int k = 0; k <= MAX_ELEMENTS; k++) begin
      f   = fact_of(k);
      len = bit_len(f);
      if (len <= RANK_W) begin
        t[k] = DIV_W'(f << (RANK_W - len));
      end else begin
        t[k] = '0;
      end
    end
    return t;
  endfunction

  function automatic pu_cnt_tbl_t build_mod_steps();
    pu_cnt_tbl_t t;
    int          len;
    for (int k = 0; k <= MAX_ELEMENTS; k++) begin
      len = bit_len(fact_of(k));
      if (len <= RANK_W) begin
        t[k] = CNT_W'(RANK_W - len + 1);
      end else begin
        t[k] = '0;
      end
    end
    return t;
  endfunction

  // digit j: quotient below j+1, so max(bit_len(j), 1) quotient bits
  function automatic pu_div_tbl_t build_dig_div();
    pu_div_tbl_t t;
    int          s;
    for (int k = 0; k <= MAX_ELEMENTS; k++) begin
      s    = (bit_len(64'(k)) > 1) ? bit_len(64'(k)) : 1;
      t[k] = DIV_W'(fact_of(k) << (s - 1));
    end
    return t;
  endfunction

  function automatic pu_cnt_tbl_t build_dig_steps();
    pu_cnt_tbl_t t;
    int          s;
    for (int k = 0; k <= MAX_ELEMENTS; k++) begin
      s    = (bit_len(64'(k)) > 1) ? bit_len(64'(k)) : 1;
      t[k] = CNT_W'(s);
    end
    return t;
  endfunction

  localparam pu_div_tbl_t MOD_DIV   = build_mod_div();
  localparam pu_cnt_tbl_t MOD_STEPS = build_mod_steps();
  localparam pu_div_tbl_t DIG_DIV   = build_dig_div();
  localparam pu_cnt_tbl_t DIG_STEPS = build_dig_steps();

  typedef logic [MAX_ELEMENTS-1:0][DIG_W-1:0] pu_digits_t;

  // digit vector passed from the divider to the adjust stage
  typedef struct packed {
    pu_digits_t     digits;
    logic [N_W-1:0] size;
  } pu_hand_t;

endpackage

FILE: rtl/pu_rank_if.sv
interface pu_rank_if;
  import pu_pkg::*;

  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

FILE: rtl/pu_perm_if.sv
interface pu_perm_if;
  import pu_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] element;
  logic             last;

  modport source (output valid, output position, output element, output last, input ready);
  modport sink   (input valid, input position, input element, input last, output ready);
endinterface

FILE: rtl/pu_digits.sv
module pu_digits (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [pu_pkg::N_W-1:0]  size,
  pu_rank_if.sink                 in_ch,
  output logic                    hand_valid,
  input  logic                    hand_ready,
  output pu_pkg::pu_hand_t        hand
);
  import pu_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_DIG, S_HOLD} state_t;

  state_t           state_r, state_nxt;
  pu_div_t          rem_r, rem_nxt;
  pu_div_t          dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIG_W-1:0] q_r, q_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  pu_digits_t       dig_r, dig_nxt;

  logic             ge;
  logic [DIG_W-1:0] q_step;
  logic [N_W-1:0]   j_cur;
  logic [N_W-1:0]   j_next;
  logic [N_W-1:0]   first_j;

  // one restoring step per cycle
  assign ge      = rem_r >= dvs_r;
  assign q_step  = DIG_W'({q_r, ge});
  assign j_cur   = n_r - N_W'(1) - N_W'(k_r);
  assign j_next  = j_cur - N_W'(1);
  assign first_j = size - N_W'(1);

  assign in_ch.ready = (state_r == S_IDLE);
  assign hand_valid  = (state_r == S_HOLD);
  assign hand.digits = dig_r;
  assign hand.size   = n_r;

  // next state: modulo reduction, then one factorial digit after another
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    q_nxt     = q_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    dig_nxt   = dig_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          rem_nxt = DIV_W'(in_ch.rank);
          n_nxt   = size;
          k_nxt   = '0;
          q_nxt   = '0;
          if (MOD_STEPS[size] != '0) begin
            state_nxt = S_MOD;
            dvs_nxt   = MOD_DIV[size];
            cnt_nxt   = MOD_STEPS[size] - CNT_W'(1);
          end else begin
            state_nxt = S_DIG;
            dvs_nxt   = DIG_DIV[first_j];
            cnt_nxt   = DIG_STEPS[first_j] - CNT_W'(1);
          end
        end
      end
      S_MOD: begin
        if (ge) begin
          rem_nxt = rem_r - dvs_r;
        end
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_DIG;
          dvs_nxt   = DIG_DIV[j_cur];
          cnt_nxt   = DIG_STEPS[j_cur] - CNT_W'(1);
          q_nxt     = '0;
        end
      end
      S_DIG: begin
        if (ge) begin
          rem_nxt = rem_r - dvs_r;
        end
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        q_nxt   = q_step;
        if (cnt_r == '0) begin
          dig_nxt[k_r] = q_step;
          if (j_cur == '0) begin
            state_nxt = S_HOLD;
          end else begin
            k_nxt   = k_r + IDX_W'(1);
            dvs_nxt = DIG_DIV[j_next];
            cnt_nxt = DIG_STEPS[j_next] - CNT_W'(1);
            q_nxt   = '0;
          end
        end
      end
      S_HOLD: begin
        if (hand_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    k_r   <= k_nxt;
    n_r   <= n_nxt;
    dig_r <= dig_nxt;
  end

endmodule

FILE: rtl/pu_adjust.sv
module pu_adjust (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             hand_valid,
  output logic             hand_ready,
  input  pu_pkg::pu_hand_t hand,
  pu_perm_if.source        out_ch
);
  import pu_pkg::*;

  typedef enum logic {A_IDLE, A_WORK} state_t;

  state_t           state_r, state_nxt;
  pu_digits_t       src_r, src_nxt;
  pu_digits_t       hist_r, hist_nxt;
  pu_digits_t       scan_r, scan_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  logic [IDX_W-1:0] p_r, p_nxt;
  logic [IDX_W-1:0] left_r, left_nxt;
  logic [DIG_W-1:0] v_r, v_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [POS_W-1:0] out_elem_r, out_elem_nxt;
  logic             out_last_r, out_last_nxt;

  logic [DIG_W-1:0] v_c;
  logic             chunk_done;
  logic             slot_free;
  logic             is_last;
  logic [IDX_W-1:0] p_inc;
  pu_digits_t       hist_push;

  // raise the digit once per earlier digit not above it, newest first
  always_comb begin
    v_c = v_r;
    for (int l = 0; l < ADJ_LANES; l++) begin
      if (l < int'(left_r) && scan_r[l] <= v_c) begin
        v_c = v_c + DIG_W'(1);
      end
    end
  end

  assign chunk_done = int'(left_r) <= ADJ_LANES;
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign is_last    = N_W'(p_r) == n_r - N_W'(1);
  assign p_inc      = p_r + IDX_W'(1);
  assign hist_push  = {hist_r[MAX_ELEMENTS-2:0], src_r[0]};

  assign hand_ready      = (state_r == A_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.element  = out_elem_r;
  assign out_ch.last     = out_last_r;

  // walk positions in order, emit each into the output register
  always_comb begin
    state_nxt     = state_r;
    src_nxt       = src_r;
    hist_nxt      = hist_r;
    scan_nxt      = scan_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    left_nxt      = left_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pos_nxt   = out_pos_r;
    out_elem_nxt  = out_elem_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      A_IDLE: begin
        if (hand_valid) begin
          state_nxt = A_WORK;
          src_nxt   = hand.digits;
          n_nxt     = hand.size;
          p_nxt     = '0;
          left_nxt  = '0;
          v_nxt     = hand.digits[0];
        end
      end
      A_WORK: begin
        v_nxt    = v_c;
        scan_nxt = scan_r >> (ADJ_LANES * DIG_W);
        left_nxt = chunk_done ? '0 : left_r - IDX_W'(ADJ_LANES);
        if (chunk_done && slot_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = POS_W'(p_r);
          out_elem_nxt  = POS_W'(v_c);
          out_last_nxt  = is_last;
          hist_nxt      = hist_push;
          if (is_last) begin
            state_nxt = A_IDLE;
          end else begin
            src_nxt  = src_r >> DIG_W;
            p_nxt    = p_inc;
            v_nxt    = src_r[1];
            scan_nxt = hist_push;
            left_nxt = p_inc;
          end
        end
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= A_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    src_r      <= src_nxt;
    hist_r     <= hist_nxt;
    scan_r     <= scan_nxt;
    n_r        <= n_nxt;
    p_r        <= p_nxt;
    left_r     <= left_nxt;
    v_r        <= v_nxt;
    out_pos_r  <= out_pos_nxt;
    out_elem_r <= out_elem_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

FILE: rtl/permutation_unrank_top.sv
// the divider makes one quotient bit per cycle while it works on a rank, then holds its
//   digits until the adjust stage takes them, and takes a new rank only once idle again
// the adjust stage emits the results one position after another, each waiting on out_ch.ready
// reset: synchronous active-low; size register returns to 16, no request pending
module permutation_unrank_top (
  input  logic                      clk,
  input  logic                      rst_n,
  pu_rank_if.sink                   in_ch,
  pu_perm_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [pu_pkg::SIZE_W-1:0] cfg_wdata
);
  import pu_pkg::*;

  logic [SIZE_W-1:0] size_r;
  logic [N_W-1:0]    n_eff;
  logic              hand_valid;
  logic              hand_ready;
  pu_hand_t          hand;

  // size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // clamp the size to 1..MAX_ELEMENTS
  always_comb begin
    if (size_r == '0) begin
      n_eff = N_W'(1);
    end else if (int'(size_r) > MAX_ELEMENTS) begin
      n_eff = N_W'(MAX_ELEMENTS);
    end else begin
      n_eff = N_W'(size_r);
    end
  end

  pu_digits u_digits (
    .clk        (clk),
    .rst_n      (rst_n),
    .size       (n_eff),
    .in_ch      (in_ch),
    .hand_valid (hand_valid),
    .hand_ready (hand_ready),
    .hand       (hand)
  );

  pu_adjust u_adjust (
    .clk        (clk),
    .rst_n      (rst_n),
    .hand_valid (hand_valid),
    .hand_ready (hand_ready),
    .hand       (hand),
    .out_ch     (out_ch)
  );

  // divider never takes a request while its digits wait for handoff
  a_no_accept_during_hand: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !hand_valid)
    else $error("rank request taken while digits await handoff");

  // every element lies inside the permutation
  a_element_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> int'(out_ch.element) < int'(n_eff))
    else $error("element outside permutation");

  // last marks exactly the final position
  a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last == (int'(out_ch.position) == int'(n_eff) - 1)))
    else $error("last flag does not match position");

  // a new permutation starts at position zero
  a_first_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last ##1 out_ch.valid |-> out_ch.position == '0)
    else $error("permutation does not start at position zero");

endmodule
